@@ rtl/parse_integer_any_radix_unit_assert.svh @@
// Assertion macros for the integer parser. Each check is sampled on the rising
// edge of clk and is switched off while rst is high.
`ifndef PARSE_INTEGER_ANY_RADIX_UNIT_ASSERT_SVH
`define PARSE_INTEGER_ANY_RADIX_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PIAU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("parser check failed");
`define PIAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("parser check failed");
`else
`define PIAU_ASSERT_SAME(label, ante, cons)
`define PIAU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/piau_pkg.sv @@
`default_nettype none

package piau_pkg;

  localparam int CHAR_SLOTS  = 16;
  localparam int DIGIT_W     = $clog2(CHAR_SLOTS);
  localparam int LEN_W       = 5;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_BASE_LENGTH = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW   = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_ALPHABET = 2'd1,
    ST_BAD_CHAR     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_DIGIT = 2'd0,
    OP_BAD   = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  base_length;
    logic [DATA_W-1:0] chars_low;
    logic [DATA_W-1:0] chars_high;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   base;
    logic               negative;
    logic               alpha_bad;
  } entry_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [7:0] slot_char(cfg_t cfg, int unsigned idx);
    logic [7:0] c;
    if (idx < 8) begin
      c = cfg.chars_low[8*idx +: 8];
    end else begin
      c = cfg.chars_high[8*(idx-8) +: 8];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/parse_integer_any_radix_unit.sv @@
// A terminating zero byte passes through the queue and then the output register
// when both are empty. Throughput: one byte per cycle while the queue is not full;
// the back end runs one 32-bit multiply-accumulate per cycle while digits are queued,
// and a four-entry queue separates it from the byte classifier.
// Reset (synchronous, rst high) clears the alphabet registers, parser state, queue and
// the output valid.
`default_nettype none

`include "parse_integer_any_radix_unit_assert.svh"

module parse_integer_any_radix_unit #(
  parameter int MAX_RADIX = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [piau_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [piau_pkg::DATA_W-1:0]   pwdata,
  output logic [piau_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    char_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 value,
  output logic [1:0]                         status
);

  piau_pkg::cfg_t   cfg;
  piau_pkg::entry_t push_entry;
  piau_pkg::entry_t head;
  piau_pkg::qstat_t q_stat;
  logic             push;
  logic             pop;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             lone_end;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[piau_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_length <= '0;
      cfg.chars_low   <= '0;
      cfg.chars_high  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        piau_pkg::REG_BASE_LENGTH: cfg.base_length <= pwdata[piau_pkg::LEN_W-1:0];
        piau_pkg::REG_CHARS_LOW:   cfg.chars_low   <= pwdata;
        piau_pkg::REG_CHARS_HIGH:  cfg.chars_high  <= pwdata;
        default:                   cfg.chars_low   <= cfg.chars_low;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      piau_pkg::REG_BASE_LENGTH: prdata = piau_pkg::DATA_W'(cfg.base_length);
      piau_pkg::REG_CHARS_LOW:   prdata = cfg.chars_low;
      piau_pkg::REG_CHARS_HIGH:  prdata = cfg.chars_high;
      default:                   prdata = '0;
    endcase
  end

  piau_front #(
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .char_byte  (char_byte),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  piau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  piau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  assign lone_end = in_valid && !in_stall && (char_byte == piau_pkg::CH_NUL) &&
                    q_stat.empty && !out_valid;

  // A failed parse never carries a value.
  `PIAU_ASSERT_SAME(a_err_zero, out_valid && status != piau_pkg::ST_OK, value == 32'sd0)
  // The queue never holds more entries than it has slots.
  `PIAU_ASSERT_SAME(a_q_bound, 1'b1, q_stat.count <= piau_pkg::QCNT_W'(piau_pkg::QUEUE_DEPTH))
  // With nothing ahead of it, a terminating byte reaches the output through the queue.
  `PIAU_ASSERT_NEXT(a_end_latency, lone_end, ##1 out_valid)

endmodule

`default_nettype wire

@@ rtl/piau_front.sv @@
`default_nettype none

module piau_front #(
  parameter int MAX_RADIX = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire piau_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  input  wire logic [7:0]        char_byte,
  output logic                   in_stall,
  input  wire piau_pkg::qstat_t  q_stat,
  output logic                   push,
  output piau_pkg::entry_t       push_entry
);

  // Slots beyond the radix limit can never hold a usable digit.
  localparam int NUM_CHARS = (MAX_RADIX < piau_pkg::CHAR_SLOTS) ?
                             MAX_RADIX : piau_pkg::CHAR_SLOTS;

  typedef enum logic [1:0] {
    PH_LEAD = 2'b01,
    PH_NUM  = 2'b10
  } phase_t;

  phase_t phase, phase_next;
  logic   negative, negative_next;

  logic [NUM_CHARS-1:0]         hit;
  logic [piau_pkg::DIGIT_W-1:0] digit;
  logic                         alpha_ok;
  logic                         is_space;
  logic                         accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign is_space = (char_byte == piau_pkg::CH_SPACE) || (char_byte == piau_pkg::CH_LF) ||
                    (char_byte == piau_pkg::CH_TAB) || (char_byte == piau_pkg::CH_CR) ||
                    (char_byte == piau_pkg::CH_FF) || (char_byte == piau_pkg::CH_VT);

  always_comb begin
    hit = '0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      hit[i] = (piau_pkg::LEN_W'(i) < cfg.base_length) &&
               (piau_pkg::slot_char(cfg, i) == char_byte);
    end
  end

  // The lowest matching slot wins.
  always_comb begin
    digit = '0;
    for (int i = NUM_CHARS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        digit = piau_pkg::DIGIT_W'(i);
      end
    end
  end

  // Every slot in use must be unique and must not be NUL, '+' or '-'.
  always_comb begin
    logic [7:0] ci;
    ci = '0;
    alpha_ok = (cfg.base_length >= piau_pkg::LEN_W'(2)) &&
               (cfg.base_length <= piau_pkg::LEN_W'(NUM_CHARS));
    for (int i = 0; i < piau_pkg::CHAR_SLOTS; i++) begin
      ci = piau_pkg::slot_char(cfg, i);
      if (piau_pkg::LEN_W'(i) < cfg.base_length) begin
        if (ci == piau_pkg::CH_NUL || ci == piau_pkg::CH_PLUS || ci == piau_pkg::CH_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < piau_pkg::CHAR_SLOTS; j++) begin
          if ((piau_pkg::LEN_W'(j) < cfg.base_length) && (piau_pkg::slot_char(cfg, j) == ci)) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    negative_next        = negative;
    push                 = 1'b0;
    push_entry.op        = (|hit) ? piau_pkg::OP_DIGIT : piau_pkg::OP_BAD;
    push_entry.digit     = digit;
    push_entry.base      = cfg.base_length;
    push_entry.negative  = negative;
    push_entry.alpha_bad = !alpha_ok;
    if (accept) begin
      priority if (char_byte == piau_pkg::CH_NUL) begin
        push          = 1'b1;
        push_entry.op = piau_pkg::OP_END;
        phase_next    = PH_LEAD;
        negative_next = 1'b0;
      end else if (phase == PH_LEAD && is_space) begin
        phase_next = PH_LEAD;
      end else if (phase == PH_LEAD && char_byte == piau_pkg::CH_MINUS) begin
        phase_next    = PH_NUM;
        negative_next = 1'b1;
      end else if (phase == PH_LEAD && char_byte == piau_pkg::CH_PLUS) begin
        phase_next = PH_NUM;
      end else begin
        phase_next = PH_NUM;
        push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      negative <= 1'b0;
    end else begin
      phase    <= phase_next;
      negative <= negative_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/piau_queue.sv @@
`default_nettype none

module piau_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire piau_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output piau_pkg::entry_t       head,
  output piau_pkg::qstat_t       q_stat
);

  piau_pkg::entry_t mem [piau_pkg::QUEUE_DEPTH];

  logic [piau_pkg::QPTR_W-1:0] wr_ptr;
  logic [piau_pkg::QPTR_W-1:0] rd_ptr;
  logic [piau_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign q_stat.count = count;
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == piau_pkg::QCNT_W'(piau_pkg::QUEUE_DEPTH));

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + piau_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + piau_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + piau_pkg::QCNT_W'(1);
        2'b01:   count <= count - piau_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/piau_back.sv @@
`default_nettype none

module piau_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire piau_pkg::entry_t  head,
  input  wire piau_pkg::qstat_t  q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     value,
  output logic [1:0]             status
);

  logic [31:0]       acc;
  logic              bad_char;
  logic [31:0]       mac;
  piau_pkg::status_t end_status;
  logic [31:0]       end_value;
  logic              out_free;
  piau_pkg::status_t status_q;

  assign out_free = !out_valid || !out_stall;
  // Digits and bad bytes drain every cycle; the end marker waits for the output register.
  assign pop = !q_stat.empty && ((head.op != piau_pkg::OP_END) || out_free);

  assign mac = acc * 32'(head.base) + 32'(head.digit);

  always_comb begin
    priority if (head.alpha_bad) begin
      end_status = piau_pkg::ST_BAD_ALPHABET;
    end else if (bad_char) begin
      end_status = piau_pkg::ST_BAD_CHAR;
    end else begin
      end_status = piau_pkg::ST_OK;
    end
    if (end_status != piau_pkg::ST_OK) begin
      end_value = '0;
    end else if (head.negative) begin
      end_value = 32'd0 - acc;
    end else begin
      end_value = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      bad_char  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        unique case (head.op)
          piau_pkg::OP_DIGIT: acc <= mac;
          piau_pkg::OP_BAD:   bad_char <= 1'b1;
          piau_pkg::OP_END: begin
            acc      <= '0;
            bad_char <= 1'b0;
          end
          default: acc <= acc;
        endcase
      end
      if (pop && head.op == piau_pkg::OP_END) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op == piau_pkg::OP_END) begin
      value    <= end_value;
      status_q <= end_status;
    end
  end

  assign status = status_q;

endmodule

`default_nettype wire
